// File: design/utf8d_pkg.sv
`default_nettype none

package utf8d_pkg;

    // fixed field widths
    localparam int BYTE_W  = 8;
    localparam int CP_W    = 21;
    localparam int USED_W  = 3;
    localparam int TOTAL_W = 32;
    localparam int DATA_W  = 56;

    // default width of the character counter
    localparam int COUNT_WIDTH_DEF = 32;

    // replacement character
    localparam logic [CP_W-1:0] REPL_CP = 21'h00FFFD;

    // one result item
    typedef struct packed {
        logic [CP_W-1:0]    code_point;
        logic [USED_W-1:0]  consumed_bytes;
        logic               replaced;
        logic               is_end;
        logic [TOTAL_W-1:0] char_total;
    } item_t;

    // all results caused by one input byte: flushed replacements, then an optional final item
    typedef struct packed {
        logic [1:0] rep_cnt;
        logic       fin_valid;
        item_t      fin;
    } batch_t;

    // continuation bytes that follow a lead, zero when it is no lead
    function automatic logic [1:0] cont_for(input logic [BYTE_W-1:0] lead);
        logic [1:0] n;
        n = 2'd0;
        if ((lead & 8'hE0) == 8'hC0)
        begin
            n = 2'd1;
        end
        else if ((lead & 8'hF0) == 8'hE0)
        begin
            n = 2'd2;
        end
        else if ((lead & 8'hF8) == 8'hF0)
        begin
            n = 2'd3;
        end
        return n;
    endfunction

    // replacement item for one bad byte
    function automatic item_t repl_item();
        item_t it;
        it.code_point     = REPL_CP;
        it.consumed_bytes = 3'd1;
        it.replaced       = 1'b1;
        it.is_end         = 1'b0;
        it.char_total     = '0;
        return it;
    endfunction

endpackage

`default_nettype wire

// File: design/utf8d_front.sv
`default_nettype none

module utf8d_front #(
    parameter int COUNT_WIDTH = utf8d_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         load,
    input  wire logic [utf8d_pkg::BYTE_W-1:0] data_byte,
    output utf8d_pkg::batch_t                 batch
);

    logic [utf8d_pkg::BYTE_W-1:0] lead_reg, lead_next;
    logic [utf8d_pkg::BYTE_W-1:0] cont0_reg, cont0_next;
    logic [utf8d_pkg::BYTE_W-1:0] cont1_reg, cont1_next;
    logic [1:0]                   gath_reg, gath_next;
    logic [COUNT_WIDTH-1:0]       counter_reg, counter_next;

    logic [1:0]                   need;
    logic                         is_cont;
    logic [COUNT_WIDTH:0]         sum_a;
    logic [COUNT_WIDTH-1:0]       sat_a;
    logic [COUNT_WIDTH:0]         sum_b;
    logic [COUNT_WIDTH-1:0]       sat_b;
    logic [utf8d_pkg::TOTAL_W-1:0] total;

    // decode of one byte against the pending sequence
    always_comb
    begin
        lead_next  = lead_reg;
        cont0_next = cont0_reg;
        cont1_next = cont1_reg;
        gath_next  = gath_reg;
        batch      = '0;
        need       = utf8d_pkg::cont_for(lead_reg);
        is_cont    = (data_byte[7:6] == 2'b10);

        if (gath_reg != 2'd0 && is_cont && need >= gath_reg)
        begin
            if (gath_reg == need)
            begin
                // sequence complete
                batch.fin_valid          = 1'b1;
                batch.fin.consumed_bytes = {1'b0, need} + 3'd1;
                unique case (need)
                    2'd1:    batch.fin.code_point = {10'd0, lead_reg[4:0], data_byte[5:0]};
                    2'd2:    batch.fin.code_point = {5'd0, lead_reg[3:0], cont0_reg[5:0],
                                                     data_byte[5:0]};
                    default: batch.fin.code_point = {lead_reg[2:0], cont0_reg[5:0],
                                                     cont1_reg[5:0], data_byte[5:0]};
                endcase
                gath_next = 2'd0;
            end
            else
            begin
                // keep gathering
                if (gath_reg == 2'd1)
                begin
                    cont0_next = data_byte;
                end
                else
                begin
                    cont1_next = data_byte;
                end
                gath_next = gath_reg + 2'd1;
            end
        end
        else
        begin
            // flush whatever is pending, then decode the byte afresh as end marker, ASCII, lead or bad byte
            batch.rep_cnt = gath_reg;
            gath_next     = 2'd0;
            if (data_byte == '0)
            begin
                batch.fin_valid  = 1'b1;
                batch.fin.is_end = 1'b1;
            end
            else if (!data_byte[7])
            begin
                batch.fin_valid          = 1'b1;
                batch.fin.code_point     = {13'd0, data_byte};
                batch.fin.consumed_bytes = 3'd1;
            end
            else if (utf8d_pkg::cont_for(data_byte) != 2'd0)
            begin
                lead_next = data_byte;
                gath_next = 2'd1;
            end
            else
            begin
                batch.fin_valid = 1'b1;
                batch.fin       = utf8d_pkg::repl_item();
            end
        end

        // saturating character count
        sum_a = {1'b0, counter_reg} + (COUNT_WIDTH + 1)'(batch.rep_cnt);
        sat_a = sum_a[COUNT_WIDTH] ? '1 : sum_a[COUNT_WIDTH-1:0];
        sum_b = {1'b0, sat_a} + (COUNT_WIDTH + 1)'(batch.fin_valid && !batch.fin.is_end);
        sat_b = sum_b[COUNT_WIDTH] ? '1 : sum_b[COUNT_WIDTH-1:0];

        if (batch.fin.is_end)
        begin
            batch.fin.char_total = total;
            counter_next         = '0;
        end
        else
        begin
            counter_next = sat_b;
        end
    end

    // reported total saturates to the field width
    generate
        if (COUNT_WIDTH > utf8d_pkg::TOTAL_W)
        begin : g_wide
            assign total = (|sat_a[COUNT_WIDTH-1:utf8d_pkg::TOTAL_W]) ? '1
                         : sat_a[utf8d_pkg::TOTAL_W-1:0];
        end
        else if (COUNT_WIDTH == utf8d_pkg::TOTAL_W)
        begin : g_equal
            assign total = sat_a;
        end
        else
        begin : g_narrow
            assign total = {{(utf8d_pkg::TOTAL_W - COUNT_WIDTH){1'b0}}, sat_a};
        end
    endgenerate

    // sequence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_reg    <= '0;
            gath_reg    <= 2'd0;
            counter_reg <= '0;
        end
        else if (load)
        begin
            lead_reg    <= lead_next;
            gath_reg    <= gath_next;
            counter_reg <= counter_next;
        end
    end

    // continuation bytes, read only once written
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cont0_reg <= cont0_next;
            cont1_reg <= cont1_next;
        end
    end

endmodule

`default_nettype wire

// File: design/utf8d_out.sv
`default_nettype none

module utf8d_out (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire utf8d_pkg::batch_t batch_in,
    output logic                   batch_free,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output utf8d_pkg::item_t       out_item
);

    logic [1:0]        rep_reg, rep_next;
    logic              fin_valid_reg, fin_valid_next;
    utf8d_pkg::item_t  fin_reg, fin_next;
    logic              out_valid_reg, out_valid_next;
    utf8d_pkg::item_t  out_reg, out_next;

    utf8d_pkg::batch_t src;
    logic              out_free;

    assign batch_free = (rep_reg == 2'd0) && !fin_valid_reg;
    assign out_free   = !out_valid_reg || out_ready;
    assign out_valid  = out_valid_reg;
    assign out_item   = out_reg;

    // pick the next item: pending batch first, else the byte decoded this cycle
    always_comb
    begin
        if (!batch_free)
        begin
            src.rep_cnt   = rep_reg;
            src.fin_valid = fin_valid_reg;
            src.fin       = fin_reg;
        end
        else if (load)
        begin
            src = batch_in;
        end
        else
        begin
            src = '0;
        end

        rep_next       = src.rep_cnt;
        fin_valid_next = src.fin_valid;
        fin_next       = src.fin;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (out_free)
        begin
            out_valid_next = (src.rep_cnt != 2'd0) || src.fin_valid;
            if (src.rep_cnt != 2'd0)
            begin
                out_next = utf8d_pkg::repl_item();
                rep_next = src.rep_cnt - 2'd1;
            end
            else
            begin
                out_next       = src.fin;
                fin_valid_next = 1'b0;
            end
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rep_reg       <= 2'd0;
            fin_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rep_reg       <= rep_next;
            fin_valid_reg <= fin_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        fin_reg <= fin_next;
        out_reg <= out_next;
    end

endmodule

`default_nettype wire

// File: design/utf8_stream_decoder.sv
// a byte's first result is registered at the output, or batch-held while stalled
// throughput: one byte per cycle while m_tready is high and each byte yields
//   at most one result; extra results go out on successive beats while a batch
//   register holds the remainder and input is held until it drains
// reset: asynchronous active-low, clears the pending sequence, count and outputs
`default_nettype none

module utf8_stream_decoder #(
    parameter int COUNT_WIDTH = utf8d_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [7:0]                    s_tdata,  // [7:0] data_byte
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [utf8d_pkg::DATA_W-1:0]       m_tdata,  // [20:0] code_point,
                                                          // [23:21] consumed_bytes,
                                                          // [55:24] char_total
    output logic                               m_tuser,  // [0] replaced
    output logic                               m_tlast   // is_end
);

    logic              load;
    logic              batch_free;
    utf8d_pkg::batch_t batch;
    utf8d_pkg::item_t  item;

    assign s_tready = batch_free;
    assign load     = s_tvalid && batch_free;

    utf8d_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .data_byte (s_tdata),
        .batch     (batch)
    );

    utf8d_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .batch_in   (batch),
        .batch_free (batch_free),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_item   (item)
    );

    // output beat packing
    assign m_tdata = {item.char_total, item.consumed_bytes, item.code_point};
    assign m_tuser = item.replaced;
    assign m_tlast = item.is_end;

    // end beat carries no code point and no byte count and is not marked replaced
    a_end_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata[23:0] == 24'd0 && !m_tuser)
        else $error("end beat carries code point or byte count");

    // total is only reported on the end beat
    a_total_end_only: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tdata[55:24] == 32'd0)
        else $error("char_total set on a non-end beat");

    // replacement beats always carry U+FFFD and consume a single byte
    a_repl_form: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[20:0] == utf8d_pkg::REPL_CP
                             && m_tdata[23:21] == 3'd1)
        else $error("malformed replacement beat");

    // after a terminating zero byte is accepted, m_tvalid is always high in the next cycle
    a_zero_yields: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tdata == 8'd0 |=> m_tvalid)
        else $error("zero byte produced no result");

endmodule

`default_nettype wire
